// ===== hdl/eur_pkg.sv =====
// Shared constants, types and helpers for the Euler rotation matrix block.
// Used by eur_trig, eur_matrix and euler_rotation_matrix; depends on nothing.
package eur_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 14;
    localparam int LANES             = 3;
    localparam int CORDIC_STEPS      = 31;
    localparam int TRIG_W            = 32;
    localparam int XY_W              = 36;
    localparam int Z_W               = 34;
    localparam int PROD_W            = 64;
    localparam int SUM_W             = 66;
    localparam int ENTRIES           = 9;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 36'sd2608131496;
    localparam logic signed [XY_W-1:0] ONE30       = 36'sd1073741824;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001
    };

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
    } trig_val_t;

    // round Q.32 to Q.30 and clamp to [-1, +1]
    function automatic logic signed [TRIG_W-1:0] round_clamp30(
        input logic signed [XY_W-1:0] v
    );
        logic signed [XY_W-1:0] r;
        begin
            r = (v + XY_W'(2)) >>> 2;
            if (r > ONE30)
                r = ONE30;
            else if (r < -ONE30)
                r = -ONE30;
            return r[TRIG_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/eur_trig.sv =====
// Pipelined CORDIC cosine/sine for the three angle lanes, one step per stage.
// Depends on eur_pkg.
module eur_trig #(
    parameter int ANGLE_BITS = eur_pkg::ANGLE_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         en,
    input  logic                                         in_valid,
    input  logic [eur_pkg::LANES-1:0][ANGLE_BITS-1:0]    angle,
    output logic                                         out_valid,
    output eur_pkg::trig_val_t [eur_pkg::LANES-1:0]      trig
);

    localparam int N = eur_pkg::CORDIC_STEPS;
    localparam int L = eur_pkg::LANES;

    logic signed [eur_pkg::XY_W-1:0] x_reg [N+1][L];
    logic signed [eur_pkg::XY_W-1:0] y_reg [N+1][L];
    logic signed [eur_pkg::Z_W-1:0]  z_reg [N+1][L];
    logic [1:0]                      q_reg [N+1][L];
    logic [N:0]                      v_reg;

    eur_pkg::trig_val_t [L-1:0] trig_reg;
    eur_pkg::trig_val_t [L-1:0] trig_next;
    logic                       out_valid_reg;

    // quadrant fold
    for (genvar l = 0; l < L; l++) begin : g_prep
        logic [31:0]                    a;
        logic [1:0]                     q_next;
        logic [31:0]                    r;
        logic signed [eur_pkg::Z_W-1:0] z_next;

        assign a      = {angle[l], {(32-ANGLE_BITS){1'b0}}};
        assign q_next = a[31:30] + {1'b0, a[29]};
        assign r      = a - {q_next, 30'd0};
        assign z_next = {{(eur_pkg::Z_W-32){r[31]}}, r};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[0][l] <= eur_pkg::CORDIC_GAIN;
                y_reg[0][l] <= '0;
                z_reg[0][l] <= z_next;
                q_reg[0][l] <= q_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        for (genvar l = 0; l < L; l++) begin : g_lane
            logic signed [eur_pkg::XY_W-1:0] dx, dy, x_next, y_next;
            logic signed [eur_pkg::Z_W-1:0]  at, z_next;

            assign dx = y_reg[k][l] >>> k;
            assign dy = x_reg[k][l] >>> k;
            assign at = $signed({{(eur_pkg::Z_W-32){1'b0}}, eur_pkg::ATAN_TURNS[k]});

            always_comb
            begin
                if (!z_reg[k][l][eur_pkg::Z_W-1])
                begin
                    x_next = x_reg[k][l] - dx;
                    y_next = y_reg[k][l] + dy;
                    z_next = z_reg[k][l] - at;
                end
                else
                begin
                    x_next = x_reg[k][l] + dx;
                    y_next = y_reg[k][l] - dy;
                    z_next = z_reg[k][l] + at;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k+1][l] <= x_next;
                    y_reg[k+1][l] <= y_next;
                    z_reg[k+1][l] <= z_next;
                    q_reg[k+1][l] <= q_reg[k][l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end
    end

    // round, clamp, unfold quadrant
    for (genvar l = 0; l < L; l++) begin : g_out
        logic signed [eur_pkg::TRIG_W-1:0] cr, sr;

        assign cr = eur_pkg::round_clamp30(x_reg[N][l]);
        assign sr = eur_pkg::round_clamp30(y_reg[N][l]);

        always_comb
        begin
            unique case (eur_pkg::quad_t'(q_reg[N][l]))
                eur_pkg::QUAD_0:
                begin
                    trig_next[l].c = cr;
                    trig_next[l].s = sr;
                end
                eur_pkg::QUAD_1:
                begin
                    trig_next[l].c = -sr;
                    trig_next[l].s = cr;
                end
                eur_pkg::QUAD_2:
                begin
                    trig_next[l].c = -cr;
                    trig_next[l].s = -sr;
                end
                default:
                begin
                    trig_next[l].c = sr;
                    trig_next[l].s = -cr;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            trig_reg <= trig_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v_reg[N];
    end

    assign trig      = trig_reg;
    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/eur_matrix.sv =====
// Five-stage product/sum pipeline forming the nine rotation matrix entries.
// Depends on eur_pkg.
module eur_matrix #(
    parameter int FRACTION_BITS = eur_pkg::FRACTION_BITS_DEF,
    localparam int OUT_W        = FRACTION_BITS + 2
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          en,
    input  logic                                          in_valid,
    input  eur_pkg::trig_val_t [eur_pkg::LANES-1:0]       trig,
    output logic                                          out_valid,
    output logic [eur_pkg::ENTRIES-1:0][OUT_W-1:0]        m
);

    localparam int PW = eur_pkg::PROD_W;
    localparam int SW = eur_pkg::SUM_W;
    localparam int TW = eur_pkg::TRIG_W;

    logic signed [TW-1:0] cx, sx, cy, sy, cz, sz;
    assign cx = trig[0].c;
    assign sx = trig[0].s;
    assign cy = trig[1].c;
    assign sy = trig[1].s;
    assign cz = trig[2].c;
    assign sz = trig[2].s;

    logic [4:0] v_reg;

    // stage 1 products:
    // 0 czcy 1 szsx 2 szcx 3 czsy 4 czsx 5 szcy 6 czcx 7 szsy 8 cxsy 9 cxcy
    logic signed [PW-1:0] p1_reg [10];
    logic signed [PW-1:0] p1_next [10];
    logic signed [TW-1:0] sx1_reg, sy1_reg, cy1_reg;

    always_comb
    begin
        p1_next[0] = PW'(cz) * PW'(cy);
        p1_next[1] = PW'(sz) * PW'(sx);
        p1_next[2] = PW'(sz) * PW'(cx);
        p1_next[3] = PW'(cz) * PW'(sy);
        p1_next[4] = PW'(cz) * PW'(sx);
        p1_next[5] = PW'(sz) * PW'(cy);
        p1_next[6] = PW'(cz) * PW'(cx);
        p1_next[7] = PW'(sz) * PW'(sy);
        p1_next[8] = PW'(cx) * PW'(sy);
        p1_next[9] = PW'(cx) * PW'(cy);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= p1_next;
            sx1_reg <= sx;
            sy1_reg <= sy;
            cy1_reg <= cy;
        end
    end

    // stage 2: round the partial triple products to Q.30
    logic signed [PW-1:0] szsx_full, czsx_full;
    logic signed [TW-1:0] szsx_next, czsx_next;
    logic signed [TW-1:0] szsx2_reg, czsx2_reg, sx2_reg, sy2_reg, cy2_reg;
    logic signed [PW-1:0] p2_reg [10];

    assign szsx_full = (p1_reg[1] + (PW'(1) <<< 29)) >>> 30;
    assign czsx_full = (p1_reg[4] + (PW'(1) <<< 29)) >>> 30;
    assign szsx_next = szsx_full[TW-1:0];
    assign czsx_next = czsx_full[TW-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_reg    <= p1_reg;
            szsx2_reg <= szsx_next;
            czsx2_reg <= czsx_next;
            sx2_reg   <= sx1_reg;
            sy2_reg   <= sy1_reg;
            cy2_reg   <= cy1_reg;
        end
    end

    // stage 3: third factor
    logic signed [PW-1:0] t_next [4];
    logic signed [PW-1:0] t3_reg [4];
    logic signed [PW-1:0] p3_reg [10];
    logic signed [TW-1:0] sx3_reg;

    always_comb
    begin
        t_next[0] = PW'(szsx2_reg) * PW'(sy2_reg);
        t_next[1] = PW'(szsx2_reg) * PW'(cy2_reg);
        t_next[2] = PW'(czsx2_reg) * PW'(sy2_reg);
        t_next[3] = PW'(czsx2_reg) * PW'(cy2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t3_reg  <= t_next;
            p3_reg  <= p2_reg;
            sx3_reg <= sx2_reg;
        end
    end

    // stage 4: sums
    logic signed [SW-1:0] e_next [eur_pkg::ENTRIES];
    logic signed [SW-1:0] e4_reg [eur_pkg::ENTRIES];
    logic signed [SW-1:0] sx_ext;

    assign sx_ext = {{(SW-TW){sx3_reg[TW-1]}}, sx3_reg};

    always_comb
    begin
        e_next[0] = SW'(p3_reg[0]) + SW'(t3_reg[0]);
        e_next[1] = SW'(p3_reg[2]);
        e_next[2] = SW'(t3_reg[1]) - SW'(p3_reg[3]);
        e_next[3] = SW'(t3_reg[2]) - SW'(p3_reg[5]);
        e_next[4] = SW'(p3_reg[6]);
        e_next[5] = SW'(p3_reg[7]) + SW'(t3_reg[3]);
        e_next[6] = SW'(p3_reg[8]);
        e_next[7] = -(sx_ext <<< 30);
        e_next[8] = SW'(p3_reg[9]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            e4_reg <= e_next;
    end

    // stage 5: round half up to Q1.F and saturate
    logic [eur_pkg::ENTRIES-1:0][OUT_W-1:0] m_next;
    logic [eur_pkg::ENTRIES-1:0][OUT_W-1:0] m_reg;

    for (genvar i = 0; i < eur_pkg::ENTRIES; i++) begin : g_fin
        logic signed [SW-1:0] r;
        logic signed [SW-1:0] lim;

        assign lim = SW'(1) <<< FRACTION_BITS;
        assign r   = (e4_reg[i] + (SW'(1) <<< (59 - FRACTION_BITS))) >>> (60 - FRACTION_BITS);

        always_comb
        begin
            priority if (r > lim)
                m_next[i] = lim[OUT_W-1:0];
            else if (r < -lim)
                m_next[i] = OUT_W'(-lim);
            else
                m_next[i] = r[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            m_reg <= m_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], in_valid};
    end

    assign m         = m_reg;
    assign out_valid = v_reg[4];

endmodule

// ===== hdl/euler_rotation_matrix.sv =====
// Pipeline: angle fold, 31 CORDIC steps, trig rounding, 5 matrix stages.
// Throughput: one request per cycle; the whole pipeline holds while the output
// request waits, and the input is not ready during that time.
// Reset: asynchronous active-low rst_n clears all valid bits; data is not reset.
// Top level: Euler angles (Rz*Rx*Ry) to 3x3 rotation matrix. Uses eur_pkg,
// eur_trig and eur_matrix.
module euler_rotation_matrix #(
    parameter int ANGLE_BITS    = eur_pkg::ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = eur_pkg::FRACTION_BITS_DEF,
    localparam int IN_W         = ((3 * ANGLE_BITS + 7) / 8) * 8,
    localparam int OUT_W        = FRACTION_BITS + 2,
    localparam int M_W          = ((eur_pkg::ENTRIES * OUT_W + 7) / 8) * 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [IN_W-1:0] s_axis_tdata,  // angle_x, angle_y, angle_z
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [M_W-1:0]  m_axis_tdata   // m00, m01, m02, m10, m11, m12, m20, m21, m22
);

    logic                                          en;
    logic [eur_pkg::LANES-1:0][ANGLE_BITS-1:0]     angle;
    logic                                          trig_valid;
    eur_pkg::trig_val_t [eur_pkg::LANES-1:0]       trig;
    logic [eur_pkg::ENTRIES-1:0][OUT_W-1:0]        m;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    for (genvar l = 0; l < eur_pkg::LANES; l++) begin : g_ang
        assign angle[l] = s_axis_tdata[l*ANGLE_BITS +: ANGLE_BITS];
    end

    eur_trig #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .angle     (angle),
        .out_valid (trig_valid),
        .trig      (trig)
    );

    eur_matrix #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (trig_valid),
        .trig      (trig),
        .out_valid (m_axis_tvalid),
        .m         (m)
    );

    assign m_axis_tdata = M_W'(m);

endmodule

// ===== dv/tb.sv =====
// Testbench for euler_rotation_matrix: angle requests in, checks all nine Q1.14 entries.
// Uses eur_pkg for the quadrant type and the arctangent table; needs only the RTL.
`timescale 1ns / 100ps

module tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata = '0;   // angle_x, angle_y, angle_z
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;        // m00, m01, m02, m10, m11, m12, m20, m21, m22

    logic [143:0] matrix_q[$];
    bit           steady = 1'b0;
    int           mismatches = 0;
    int           idle_cycles = 0;

    always #4 clk = ~clk;

    euler_rotation_matrix u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // cosine and sine in Q.30 of a 16-bit binary angle
    task automatic sin_cos(input logic [15:0] angle, output longint c, output longint s);
        logic [31:0]    a;
        logic [31:0]    r;
        eur_pkg::quad_t q;
        longint         x;
        longint         y;
        longint         z;
        longint         dx;
        longint         dy;
        longint         cr;
        longint         sr;
        a = {angle, 16'h0};
        q = eur_pkg::quad_t'(2'((a + 32'h2000_0000) >> 30));
        r = a - ({30'h0, q} << 30);
        z = longint'(signed'(r));
        x = 64'sd2608131496;
        y = 0;
        for (int i = 0; i < eur_pkg::CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(eur_pkg::ATAN_TURNS[i]);
            end
            else
            begin
                x += dx; y -= dy; z += longint'(eur_pkg::ATAN_TURNS[i]);
            end
        end
        cr = (x + 2) >>> 2;
        sr = (y + 2) >>> 2;
        if (cr > (64'sd1 <<< 30)) cr = 64'sd1 <<< 30;
        if (cr < -(64'sd1 <<< 30)) cr = -(64'sd1 <<< 30);
        if (sr > (64'sd1 <<< 30)) sr = 64'sd1 <<< 30;
        if (sr < -(64'sd1 <<< 30)) sr = -(64'sd1 <<< 30);
        case (q)
            eur_pkg::QUAD_0: begin c = cr;  s = sr;  end
            eur_pkg::QUAD_1: begin c = -sr; s = cr;  end
            eur_pkg::QUAD_2: begin c = -cr; s = -sr; end
            default: begin c = sr; s = -cr; end
        endcase
    endtask

    function automatic longint triple(longint a, longint b, longint c);
        return ((a * b + (64'sd1 <<< 29)) >>> 30) * c;
    endfunction

    function automatic logic [15:0] to_q14(longint v);
        longint r;
        r = (v + (64'sd1 <<< 45)) >>> 46;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    task automatic rotation_matrix(input logic [47:0] angles, output logic [143:0] m);
        longint cx, sx, cy, sy, cz, sz;
        sin_cos(angles[15:0], cx, sx);
        sin_cos(angles[31:16], cy, sy);
        sin_cos(angles[47:32], cz, sz);
        m[15:0]    = to_q14(cz * cy + triple(sz, sx, sy));
        m[31:16]   = to_q14(sz * cx);
        m[47:32]   = to_q14(triple(sz, sx, cy) - cz * sy);
        m[63:48]   = to_q14(triple(cz, sx, sy) - sz * cy);
        m[79:64]   = to_q14(cz * cx);
        m[95:80]   = to_q14(sz * sy + triple(cz, sx, cy));
        m[111:96]  = to_q14(cx * sy);
        m[127:112] = to_q14(sx * -(64'sd1 <<< 30));
        m[143:128] = to_q14(cx * cy);
    endtask

    task automatic send_angles(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az);
        logic [143:0] m;
        while (!steady && $urandom_range(99) < 36)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {az, ay, ax};
        do @(posedge clk); while (!s_axis_tready);
        rotation_matrix({az, ay, ax}, m);
        matrix_q = {matrix_q, m};
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic test_directed();
        logic [15:0] pick[12] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
                                  16'h2000, 16'h1FFF, 16'h6000, 16'hA000, 16'hE000,
                                  16'h0001, 16'h7FFF};
        for (int i = 0; i < 12; i++)
            send_angles(pick[i], pick[(i + 3) % 12], pick[(i + 7) % 12]);
        send_angles(16'h4000, 16'h4000, 16'h4000);
        send_angles(16'h8000, 16'h0000, 16'hC000);
        send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_angles(16'h5555, 16'hAAAA, 16'h0000);
    endtask

    function automatic logic [15:0] rand_angle();
        logic [15:0] base[8] = '{16'h0000, 16'h2000, 16'h4000, 16'h6000,
                                 16'h8000, 16'hA000, 16'hC000, 16'hE000};
        if ($urandom_range(9) == 0)
            return base[$urandom_range(7)] + 16'($urandom_range(4)) - 16'd2;
        return 16'($urandom);
    endfunction

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_angles(rand_angle(), rand_angle(), rand_angle());
    endtask

    task automatic test_full_rate(input int count);
        steady = 1'b1;
        test_random(count);
        steady = 1'b0;
    endtask

    always @(negedge clk)
        m_axis_tready <= steady || ($urandom_range(99) >= 36);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (matrix_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_axis_tdata);
            end
            else
            begin
                logic [143:0] exp_m;
                exp_m = matrix_q.pop_front();
                for (int k = 0; k < eur_pkg::ENTRIES; k++)
                    if (m_axis_tdata[16*k +: 16] !== exp_m[16*k +: 16])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("m%0d%0d: expected %0d, got %0d", k / 3, k % 3,
                                     $signed(exp_m[16*k +: 16]),
                                     $signed(m_axis_tdata[16*k +: 16]));
                    end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("euler_rotation_matrix test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(250);
        test_full_rate(100);
        test_random(200);
        while (matrix_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("euler_rotation_matrix test passed");
        else
            $display("euler_rotation_matrix test failed");
        $finish;
    end

endmodule
